// File: hw/rtl/bitmap_id_allocator_defines.svh
// Assertion macros used by the bitmap id allocator checker.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bia_pkg.sv
// Shared types and constants of the bitmap id allocator.
`default_nettype none
package bia_pkg;

  // Slot arithmetic width: holds pool size plus one word, and the 4096 id span.
  localparam int CW = 13;
  localparam logic [CW-1:0] ID_SPAN = 13'd4096;

  // Request codes
  localparam logic ACT_TAKE = 1'b0;
  localparam logic ACT_PUT  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  // Register index (address bit 2)
  localparam logic REG_FIRST_ID   = 1'b0;
  localparam logic REG_POOL_COUNT = 1'b1;

  // Controls for one pass of the word scan unit
  typedef struct packed {
    logic          take;   // 1: find and set lowest free slot, 0: clear slot at off
    logic          skip0;  // slot 0 maps to id 0 and must not be granted
    logic [CW-1:0] base;   // slot number of bit 0 of the current word
    logic [CW-1:0] limit;  // slots at or above this are not grantable
    logic [CW-1:0] off;    // put: slot offset within the word
  } scan_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/bia_scan_unit.sv
// Word scan unit: masks one bitmap word, finds the lowest free slot and forms the new word.
`default_nettype none
module bia_scan_unit
  import bia_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic [WORD_BITS-1:0]         word,
  input  wire scan_req_t                    req,
  output logic                              found,
  output logic [$clog2(WORD_BITS)-1:0]      bit_idx,
  output logic [WORD_BITS-1:0]              word_next
);

  localparam int BW = $clog2(WORD_BITS);

  logic [CW-1:0]        rem;
  logic [WORD_BITS-1:0] elig;
  logic [WORD_BITS-1:0] free;
  logic [WORD_BITS-1:0] one;

  // Slots left in the grantable range from this word on
  assign rem = (req.limit > req.base) ? (req.limit - req.base) : '0;

  // Mark grantable bits of this word
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      elig[b] = (CW'(b) < rem) && !(req.skip0 && (req.base == '0) && (b == 0));
    end
  end

  assign free  = ~word & elig;
  assign found = |free;

  // Lowest free bit
  always_comb begin
    bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free[b]) begin
        bit_idx = BW'(b);
      end
    end
  end

  assign one = {{(WORD_BITS-1){1'b0}}, 1'b1};

  // Set the granted bit, or clear the returned one
  assign word_next = req.take ? (word | (one << bit_idx))
                              : (word & ~(one << req.off[BW-1:0]));

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_id_allocator.sv
// Top level of the bitmap first-fit id allocator.
// Hands out ids first_id .. first_id+min(pool_count,POOL_SIZE)-1 lowest first, never
// id 0 or past 4095, and takes them back. Used bits sit in a one-port memory of
// ceil(POOL_SIZE/WORD_BITS) words; after reset a clearing pass writes zero to each
// word, one word a cycle, and no beat is taken until it ends. One request is handled
// at a time, with a single scan unit reused on every word. A take visits one word
// after another (memory read, then mask and priority encode) until a free slot turns
// up or the pool ends; a put skips to its word, reads it and clears the bit, and an
// ignored put goes straight to the result. A finished result waits in an output
// register, so the next request beat is taken while it is still stalled.
`default_nettype none
module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int POOL_SIZE = 256,
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [11:0] return_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      granted_id,
  output logic [1:0]       status,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int POOL_WORDS = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] WB_C   = CW'(WORD_BITS);
  localparam logic [CW-1:0] POOL_C = CW'(POOL_SIZE);
  localparam logic [AW-1:0] LAST_W = AW'(POOL_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEEK,
    S_FETCH,
    S_TEST,
    S_DONE
  } state_t;

  state_t         state;
  logic [11:0]    first_id;
  logic [8:0]     pool_count;
  logic [AW-1:0]  word;
  logic [CW-1:0]  base;
  logic [CW-1:0]  slot;
  logic           is_put;
  logic [11:0]    res_id;
  logic [1:0]     res_status;

  logic [WORD_BITS-1:0] used_mem [POOL_WORDS];
  logic [WORD_BITS-1:0] rdata;

  logic [CW-1:0]  n_live;
  logic [CW-1:0]  id_room;
  logic [CW-1:0]  limit;
  logic [CW-1:0]  pool_end;
  logic           put_bad;
  logic           cfg_wr;

  scan_req_t              req;
  logic                   found;
  logic [BW-1:0]          bit_idx;
  logic [WORD_BITS-1:0]   word_next;
  logic                   mem_we;
  logic [WORD_BITS-1:0]   mem_wdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_POOL_COUNT) ? {23'b0, pool_count} : {20'b0, first_id};

  // Live pool bounds
  assign n_live   = (CW'(pool_count) > POOL_C) ? POOL_C : CW'(pool_count);
  assign id_room  = ID_SPAN - CW'(first_id);
  assign limit    = (n_live < id_room) ? n_live : id_room;
  assign pool_end = CW'(first_id) + n_live;
  assign put_bad  = (return_id == 12'd0) || (return_id < first_id) ||
                    (CW'(return_id) >= pool_end);

  // Shared scan unit
  assign req.take  = !is_put;
  assign req.skip0 = (first_id == 12'd0);
  assign req.base  = base;
  assign req.limit = limit;
  assign req.off   = slot - base;

  bia_scan_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word      (rdata),
    .req       (req),
    .found     (found),
    .bit_idx   (bit_idx),
    .word_next (word_next)
  );

  // Bitmap memory: write on clear or update, read one word on fetch
  assign mem_we    = (state == S_CLEAR) || ((state == S_TEST) && (is_put || found));
  assign mem_wdata = (state == S_CLEAR) ? '0 : word_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[word] <= mem_wdata;
    end
    if (state == S_FETCH) begin
      rdata <= used_mem[word];
    end
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      word       <= '0;
      out_valid  <= 1'b0;
      first_id   <= 12'd1;
      pool_count <= 9'd256;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_FIRST_ID) begin
          first_id <= pwdata[11:0];
        end else begin
          pool_count <= pwdata[8:0];
        end
      end

      // drop the result once taken, unless a new one is loaded in its place
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (word == LAST_W) begin
            word  <= '0;
            state <= S_IDLE;
          end else begin
            word <= word + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            base   <= '0;
            word   <= '0;
            is_put <= (action == ACT_PUT);
            if (action == ACT_PUT) begin
              slot <= CW'(return_id) - CW'(first_id);
              if (put_bad) begin
                res_id     <= 12'd0;
                res_status <= ST_IGNORED;
                state      <= S_DONE;
              end else begin
                state <= S_SEEK;
              end
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_SEEK: begin
          // advance to the word that holds the returned slot
          if (slot < base + WB_C) begin
            state <= S_FETCH;
          end else begin
            base <= base + WB_C;
            word <= word + AW'(1);
          end
        end
        S_FETCH: begin
          if (!is_put && (base >= limit)) begin
            res_id     <= 12'd0;
            res_status <= ST_EXHAUSTED;
            state      <= S_DONE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (is_put) begin
            res_id     <= 12'd0;
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (found) begin
            res_id     <= first_id + base[11:0] + 12'(bit_idx);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            base  <= base + WB_C;
            word  <= word + AW'(1);
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            granted_id <= res_id;
            status     <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bia_checker.sv
// Port-level checker of the bitmap id allocator and its bind.
`default_nettype none
`include "bitmap_id_allocator_defines.svh"
module bia_checker
  import bia_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [11:0] granted_id,
  input wire logic [1:0]  status
);

  // One request at a time: busy right after a request beat
  `BIA_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")

  // A stalled result beat holds
  `BIA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted_id) && $stable(status), "stalled result changed")

  // Only defined status codes leave the block
  `BIA_ASSERT_IMP(a_status_code, out_valid, status == ST_OK || status == ST_EXHAUSTED || status == ST_IGNORED, "undefined status code")

  // Failed requests never carry an id
  `BIA_ASSERT_IMP(a_fail_no_id, out_valid && status != ST_OK, granted_id == 12'd0, "id with failed status")

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the bitmap id allocator: directed, random and back-pressure runs.
module tb_top;
  import bia_pkg::*;

  localparam int POOL_SLOTS     = 256;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [11:0] id;
    logic [1:0]  st;
  } grant_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = ACT_TAKE;
  logic [11:0] return_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] granted_id;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Own copy of the allocator state and its registers
  logic [POOL_SLOTS-1:0] slot_used = '0;
  logic [11:0]           cfg_first_id = 12'd1;
  logic [8:0]            cfg_pool_count = 9'd256;

  grant_result_t expected_grants[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  n_takes = 0;
  int  n_puts = 0;
  int  n_exhausted = 0;
  int  n_ignored = 0;
  int  n_reg_writes = 0;
  int  hold_seq = 0;
  int  quiet_cycles = 0;
  logic idle_on = 1'b1;

  bitmap_id_allocator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .return_id  (return_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted_id (granted_id),
    .status     (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk = ~clk;

  // Work out the result of one request and advance the slot map
  function automatic void predict_grant(input logic act, input logic [11:0] rid,
                                        output grant_result_t res);
    int   live;
    int   slot_id;
    logic found;
    live = (cfg_pool_count > POOL_SLOTS) ? POOL_SLOTS : int'(cfg_pool_count);
    res.id = '0;
    res.st = ST_EXHAUSTED;
    found = 1'b0;
    if (act == ACT_TAKE) begin
      // first fit; ids of zero or past the id span are never handed out
      for (int i = 0; i < live; i++) begin
        slot_id = int'(cfg_first_id) + i;
        if (!found && slot_id != 0 && slot_id < int'(ID_SPAN) && !slot_used[i]) begin
          slot_used[i] = 1'b1;
          res.id = slot_id[11:0];
          res.st = ST_OK;
          found = 1'b1;
        end
      end
    end else if (rid == 12'd0 || rid < cfg_first_id ||
                 int'(rid) >= int'(cfg_first_id) + live) begin
      res.st = ST_IGNORED;
    end else begin
      slot_used[int'(rid - cfg_first_id)] = 1'b0;
      res.st = ST_OK;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected %0h got %0h", mismatches, what, exp_v, got_v);
  endtask

  // Predict on every accepted request beat, check every accepted result beat
  always @(posedge clk) begin : beat_monitor
    grant_result_t want;
    grant_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_grants.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd0, {18'd0, granted_id, status});
        end else begin
          want = expected_grants.pop_front();
          if (granted_id !== want.id)
            report_mismatch("granted_id", {20'd0, want.id}, {20'd0, granted_id});
          if (status !== want.st)
            report_mismatch("status", {30'd0, want.st}, {30'd0, status});
        end
      end
      if (in_valid && !in_stall) begin
        predict_grant(action, return_id, got);
        expected_grants.push_back(got);
        if (action == ACT_TAKE) n_takes++;
        else n_puts++;
        if (got.st == ST_EXHAUSTED) n_exhausted++;
        if (got.st == ST_IGNORED) n_ignored++;
      end
    end
  end

  // Result-side stalls: random bursts, plus a long hold on request
  always @(posedge clk) begin : result_stall
    int hold_seen;
    int hold_left;
    int burst_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      burst_left = 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= (hold_left != 0);
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= (burst_left != 0);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               quiet_cycles, expected_grants.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request beat, with an optional idle burst first; leaves valid high
  task automatic send_request(input logic act, input logic [11:0] rid);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      action <= 1'($urandom_range(0, 1));
      return_id <= 12'($urandom_range(0, 4095));
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    return_id <= rid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly takes and in-pool returns, some zero, edge and stray ids
  task automatic send_random_request(input int take_pct);
    int live;
    int lo;
    int hi;
    int pick;
    logic [11:0] rid;
    live = (cfg_pool_count > POOL_SLOTS) ? POOL_SLOTS : int'(cfg_pool_count);
    lo = int'(cfg_first_id);
    hi = lo + live - 1;
    if (hi > 4095) hi = 4095;
    pick = $urandom_range(0, 99);
    if (pick < take_pct) begin
      send_request(ACT_TAKE, 12'($urandom_range(0, 4095)));
    end else begin
      if (pick >= 90 || live == 0 || lo > hi) begin
        case ($urandom_range(0, 4))
          0: rid = 12'd0;
          1: rid = 12'd4095;
          2: rid = cfg_first_id - 12'd1;
          3: rid = cfg_first_id + live[11:0];
          default: rid = 12'($urandom_range(0, 4095));
        endcase
      end else begin
        rid = 12'($urandom_range(lo, hi));
      end
      send_request(ACT_PUT, rid);
    end
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_grants.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register transfer: setup, access, then bus idle
  task automatic bus_transfer(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    bus_transfer(1'b0, {REG_FIRST_ID, 2'b00}, 32'd0, rd);
    if (rd !== {20'd0, cfg_first_id})
      report_mismatch("first_id readback", {20'd0, cfg_first_id}, rd);
    bus_transfer(1'b0, {REG_POOL_COUNT, 2'b00}, 32'd0, rd);
    if (rd !== {23'd0, cfg_pool_count})
      report_mismatch("pool_count readback", {23'd0, cfg_pool_count}, rd);
  endtask

  // Write both registers, junk in the unused upper bits, then read them back
  task automatic set_pool(input logic [11:0] first, input logic [8:0] count);
    logic [31:0] rd;
    bus_transfer(1'b1, {REG_FIRST_ID, 2'b00}, ($urandom & 32'hFFFF_F000) | {20'd0, first}, rd);
    cfg_first_id = first;
    bus_transfer(1'b1, {REG_POOL_COUNT, 2'b00}, ($urandom & 32'hFFFF_FE00) | {23'd0, count},
                 rd);
    cfg_pool_count = count;
    n_reg_writes += 2;
    check_registers();
  endtask

  task automatic test_register_defaults();
    check_registers();
  endtask

  // Extremes of the fields and each corner of take and put
  task automatic test_directed_cases();
    // default pool: fresh grants, double put, zero and out-of-pool puts
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_TAKE, 12'd4095);
    send_request(ACT_PUT, 12'd1);
    send_request(ACT_PUT, 12'd1);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd0);
    send_request(ACT_PUT, 12'd4095);
    send_request(ACT_PUT, 12'd257);
    send_request(ACT_PUT, 12'd256);
    wait_idle();
    // pool running past the id span, with slots still taken from before
    set_pool(12'd4094, 9'd4);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd4095);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd4094);
    send_request(ACT_PUT, 12'd4093);
    send_request(ACT_TAKE, 12'd0);
    wait_idle();
    // first id of zero: slot 0 is never granted
    set_pool(12'd0, 9'd2);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd1);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd0);
    wait_idle();
    // empty pool
    set_pool(12'd1, 9'd0);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd1);
    wait_idle();
    // count above pool size saturates
    set_pool(12'd1, 9'd511);
    send_request(ACT_TAKE, 12'd0);
    send_request(ACT_PUT, 12'd256);
    send_request(ACT_PUT, 12'd257);
    wait_idle();
  endtask

  // Phases over several pool settings; each leans to takes first, then to puts
  task automatic test_random_traffic();
    logic [11:0] first;
    logic [8:0]  count;
    int          items;
    idle_on <= 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      items = 120;
      case (phase)
        0: begin first = 12'd1;    count = 9'd256; end
        1: begin first = 12'd4000; count = 9'd200; end
        2: begin first = 12'd0;    count = 9'd65;  end
        3: begin first = 12'd4095; count = 9'd1;   end
        4: begin first = 12'd17;   count = 9'd511; end
        5: begin first = 12'($urandom_range(0, 4095)); count = 9'd0; items = 40; end
        6: begin
          first = 12'($urandom_range(0, 4095));
          count = 9'($urandom_range(1, 40));
        end
        default: begin
          first = 12'($urandom_range(0, 4095));
          count = 9'($urandom_range(0, 511));
        end
      endcase
      set_pool(first, count);
      for (int k = 0; k < items; k++)
        send_random_request((k < items / 2) ? 75 : 35);
      wait_idle();
    end
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_back_pressure();
    set_pool(12'd1, 9'd48);
    idle_on <= 1'b0;
    hold_seq <= hold_seq + 1;
    repeat (40) send_random_request(70);
    wait_idle();
  endtask

  // Closing stretch at full rate, no idling on either side
  task automatic test_steady_tail();
    set_pool(12'd200, 9'd256);
    repeat (100) send_random_request(60);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // let the used-bit clearing pass finish
    repeat (8) @(posedge clk);
    test_register_defaults();
    test_directed_cases();
    test_random_traffic();
    test_back_pressure();
    test_steady_tail();
    mismatches += expected_grants.size();
    $display("covered %0d requests (%0d takes, %0d puts), %0d results checked",
             n_takes + n_puts, n_takes, n_puts, results_seen);
    $display("  %0d exhausted, %0d ignored puts, %0d register writes, %0d mismatches",
             n_exhausted, n_ignored, n_reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
